FILE: rtl/core/etq_pkg.sv
package etq_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_STEPS = 24;
    localparam int CORDIC_STEPS =
        (CORDIC_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS : CORDIC_ITERATIONS;

    // input register, one register per iteration, sign fix register
    localparam int CORDIC_DEPTH = CORDIC_STEPS + 2;

    localparam int ANGLE_W = 16;
    localparam int QUAT_W = 16;
    localparam int Q30_W = 33;
    localparam int TRIG_W = 32;

    localparam logic signed [Q30_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [Q30_W-1:0] PI_Q30 = 33'sd3373259426;

    localparam logic [31:0] ATAN_Q30 [ATAN_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef logic signed [Q30_W-1:0] t_q30;
    typedef logic signed [TRIG_W-1:0] t_trig_val;

    typedef struct packed {
        t_trig_val c;
        t_trig_val s;
    } t_trig;

    // gain correction: floor(sqrt(floor(2^60 / (2^30 * prod(1 + 2^-2i))) * 2^30))
    function automatic logic [63:0] gain_k(input int n);
        logic [63:0] g;
        logic [63:0] rem;
        logic [63:0] inv;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bitv;
        g = 64'd1 << 30;
        for (int i = 0; i < ATAN_STEPS; i++) begin
            if (i < n) begin
                g = g + (g >> (2 * i));
            end
        end
        rem = '0;
        inv = '0;
        for (int b = 60; b >= 0; b--) begin
            rem = (rem << 1) | ((b == 60) ? 64'd1 : 64'd0);
            if (rem >= g) begin
                rem = rem - g;
                inv[b] = 1'b1;
            end
        end
        v = inv << 30;
        r = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > v) begin
                bitv = bitv >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 0) begin
                if (v >= r + bitv) begin
                    v = v - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return r;
    endfunction

    localparam logic signed [Q30_W-1:0] CORDIC_K = Q30_W'(gain_k(CORDIC_STEPS));

endpackage

FILE: rtl/core/euler_to_quaternion.sv
// Euler angles (roll, pitch, yaw, radians in signed Q2.13) to the unit
// quaternion (w, x, y, z in signed Q1.14) for the yaw-pitch-roll order.
// Input channel: i_valid with the three angles, o_stall back to the sender.
// Output channel: o_valid with the four quaternion parts, i_stall from the
// receiver. A beat moves when valid is high and stall is low.
// Throughput: one sample per cycle while the receiver does not stall.
// Path from input beat to output valid: the CORDIC pipeline (one stage per
// iteration plus its input and sign-fix registers), two multiplier stages,
// one sum stage and the output register.
// The pipeline carries a valid bit per stage and moves as one piece.
// When the receiver stalls with a result waiting, the next result drops
// into a one-entry skid register and the pipeline freezes; o_stall is that
// skid register being full, so it comes from a flop and not from i_stall.
// Nothing is lost or repeated across a stall.
// Reset (i_rst_n low, synchronous) clears all valid bits and the skid
// register; no result is pending afterward. Samples are independent.
module euler_to_quaternion (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [etq_pkg::ANGLE_W-1:0] i_roll_angle,
    input  logic signed [etq_pkg::ANGLE_W-1:0] i_pitch_angle,
    input  logic signed [etq_pkg::ANGLE_W-1:0] i_yaw_angle,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [etq_pkg::QUAT_W-1:0]  o_quat_w,
    output logic signed [etq_pkg::QUAT_W-1:0]  o_quat_x,
    output logic signed [etq_pkg::QUAT_W-1:0]  o_quat_y,
    output logic signed [etq_pkg::QUAT_W-1:0]  o_quat_z
);
    import etq_pkg::*;

    function automatic t_trig_val mul_q30(input t_trig_val a, input t_trig_val b);
        logic signed [63:0] p;
        logic signed [63:0] t;
        p = 64'(a) * 64'(b);
        p = p + 64'sd536870912;
        t = p >>> 30;
        return t[TRIG_W-1:0];
    endfunction

    function automatic logic signed [QUAT_W-1:0] sat_q14(input t_q30 v);
        logic signed [Q30_W:0] t;
        logic signed [Q30_W-16:0] r;
        t = (Q30_W+1)'(v) + 34'sd32768;
        r = (Q30_W-15)'(t >>> 16);
        if (r > 18'sd16384) begin
            return 16'sd16384;
        end else if (r < -18'sd16384) begin
            return -16'sd16384;
        end
        return r[QUAT_W-1:0];
    endfunction

    logic w_en;
    t_trig w_roll;
    t_trig w_pitch;
    t_trig w_yaw;

    logic r_vpipe [0:CORDIC_DEPTH-1];

    // roll x pitch pairs, yaw carried along
    logic r_m1_v;
    t_trig_val r_cc;
    t_trig_val r_sc;
    t_trig_val r_cs;
    t_trig_val r_ss;
    t_trig r_yaw1;

    // triple products
    logic r_m2_v;
    t_trig_val r_ccc;
    t_trig_val r_sss;
    t_trig_val r_scc;
    t_trig_val r_css;
    t_trig_val r_csc;
    t_trig_val r_scs;
    t_trig_val r_ccs;
    t_trig_val r_ssc;

    logic r_sum_v;
    t_q30 r_sw;
    t_q30 r_sx;
    t_q30 r_sy;
    t_q30 r_sz;

    logic signed [QUAT_W-1:0] n_qw;
    logic signed [QUAT_W-1:0] n_qx;
    logic signed [QUAT_W-1:0] n_qy;
    logic signed [QUAT_W-1:0] n_qz;

    logic r_out_v;
    logic signed [QUAT_W-1:0] r_qw;
    logic signed [QUAT_W-1:0] r_qx;
    logic signed [QUAT_W-1:0] r_qy;
    logic signed [QUAT_W-1:0] r_qz;

    logic r_skid_v;
    logic signed [QUAT_W-1:0] r_kw;
    logic signed [QUAT_W-1:0] r_kx;
    logic signed [QUAT_W-1:0] r_ky;
    logic signed [QUAT_W-1:0] r_kz;

    assign w_en = !r_skid_v;
    assign o_stall = r_skid_v;

    etq_cordic u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_roll_angle),
        .o_trig  (w_roll)
    );

    etq_cordic u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_pitch_angle),
        .o_trig  (w_pitch)
    );

    etq_cordic u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_yaw_angle),
        .o_trig  (w_yaw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CORDIC_DEPTH; i++) begin
                r_vpipe[i] <= 1'b0;
            end
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_sum_v <= 1'b0;
        end else if (w_en) begin
            r_vpipe[0] <= i_valid;
            for (int i = 1; i < CORDIC_DEPTH; i++) begin
                r_vpipe[i] <= r_vpipe[i-1];
            end
            r_m1_v <= r_vpipe[CORDIC_DEPTH-1];
            r_m2_v <= r_m1_v;
            r_sum_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cc <= mul_q30(w_roll.c, w_pitch.c);
            r_sc <= mul_q30(w_roll.s, w_pitch.c);
            r_cs <= mul_q30(w_roll.c, w_pitch.s);
            r_ss <= mul_q30(w_roll.s, w_pitch.s);
            r_yaw1 <= w_yaw;

            r_ccc <= mul_q30(r_cc, r_yaw1.c);
            r_sss <= mul_q30(r_ss, r_yaw1.s);
            r_scc <= mul_q30(r_sc, r_yaw1.c);
            r_css <= mul_q30(r_cs, r_yaw1.s);
            r_csc <= mul_q30(r_cs, r_yaw1.c);
            r_scs <= mul_q30(r_sc, r_yaw1.s);
            r_ccs <= mul_q30(r_cc, r_yaw1.s);
            r_ssc <= mul_q30(r_ss, r_yaw1.c);

            r_sw <= Q30_W'(r_ccc) + Q30_W'(r_sss);
            r_sx <= Q30_W'(r_scc) - Q30_W'(r_css);
            r_sy <= Q30_W'(r_csc) + Q30_W'(r_scs);
            r_sz <= Q30_W'(r_ccs) - Q30_W'(r_ssc);
        end
    end

    always_comb begin
        n_qw = sat_q14(r_sw);
        n_qx = sat_q14(r_sx);
        n_qy = sat_q14(r_sy);
        n_qz = sat_q14(r_sz);
    end

    // output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_out_v <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out_v <= r_sum_v;
        end else if (r_sum_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_stall) begin
                r_qw <= r_kw;
                r_qx <= r_kx;
                r_qy <= r_ky;
                r_qz <= r_kz;
            end
        end else if (!r_out_v || !i_stall) begin
            r_qw <= n_qw;
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qz <= n_qz;
        end else begin
            r_kw <= n_qw;
            r_kx <= n_qx;
            r_ky <= n_qy;
            r_kz <= n_qz;
        end
    end

    assign o_valid = r_out_v;
    assign o_quat_w = r_qw;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;

endmodule

FILE: rtl/core/etq_cordic.sv
module etq_cordic (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [etq_pkg::ANGLE_W-1:0] i_angle,
    output etq_pkg::t_trig                o_trig
);
    import etq_pkg::*;

    t_q30 r_x [0:CORDIC_STEPS];
    t_q30 r_y [0:CORDIC_STEPS];
    t_q30 r_z [0:CORDIC_STEPS];
    logic r_neg [0:CORDIC_STEPS];
    t_trig r_trig;

    t_q30 n_z0;
    logic n_neg0;
    t_q30 w_z_raw;
    t_q30 n_cx;
    t_q30 n_sy;

    // half angle in Q30 is the raw Q2.13 value shifted up by 16
    always_comb begin
        w_z_raw = {i_angle[ANGLE_W-1], i_angle, 16'b0};
        n_z0 = w_z_raw;
        n_neg0 = 1'b0;
        if (w_z_raw > HALF_PI_Q30) begin
            n_z0 = w_z_raw - PI_Q30;
            n_neg0 = 1'b1;
        end else if (w_z_raw < -HALF_PI_Q30) begin
            n_z0 = w_z_raw + PI_Q30;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_K;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][Q30_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed({1'b0, ATAN_Q30[i]});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed({1'b0, ATAN_Q30[i]});
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    // undo the pi shift of out-of-range half angles
    always_comb begin
        n_cx = r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        n_sy = r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.c <= n_cx[TRIG_W-1:0];
            r_trig.s <= n_sy[TRIG_W-1:0];
        end
    end

    assign o_trig = r_trig;

endmodule
